// ----- src/itp_pkg.sv -----
package itp_pkg;

	localparam logic [2:0] PH_SPACES    = 3'd0;
	localparam logic [2:0] PH_AFTERSIGN = 3'd1;
	localparam logic [2:0] PH_ZERO      = 3'd2;
	localparam logic [2:0] PH_FIRST     = 3'd3;
	localparam logic [2:0] PH_DIGITS    = 3'd4;
	localparam logic [2:0] PH_DONE      = 3'd5;

	localparam logic [1:0] BASE_DEC = 2'd0;
	localparam logic [1:0] BASE_BIN = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_INVAL = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	localparam logic [2:0] REG_SIGNED_MODE  = 3'd0;
	localparam logic [2:0] REG_LOWER_BOUND  = 3'd1;
	localparam logic [2:0] REG_UPPER_BOUND  = 3'd2;
	localparam logic [2:0] REG_SKIP_SPACES  = 3'd3;
	localparam logic [2:0] REG_ALLOW_SIGN   = 3'd4;
	localparam logic [2:0] REG_DEFAULT_BASE = 3'd5;
	localparam logic [2:0] REG_ALLOW_PREFIX = 3'd6;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CASE_BIT = 8'h20;
	localparam logic [7:0] LOW_NIB  = 8'h0F;

	localparam logic [4:0]  DIGIT_NONE = 5'd16;
	localparam logic [63:0] SIGN_BIT   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] DEC_LIMIT  = 64'h1999_9999_9999_9999;

	typedef struct packed {
		logic        signed_mode;
		logic [63:0] lower_bound;
		logic [63:0] upper_bound;
		logic        skip_spaces;
		logic        allow_sign;
		logic [1:0]  default_base;
		logic        allow_prefix;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [63:0] acc;
		logic        neg;
		logic [1:0]  base;
		logic [1:0]  err;
	} parse_st_t;

	typedef struct packed {
		logic [63:0] acc;
		logic        neg;
		logic [1:0]  err;
	} fin_t;

	function automatic logic [1:0] decode_base(input logic [1:0] b);
		logic [1:0] r;
		r = BASE_DEC;
		if (b == BASE_BIN) r = BASE_BIN;
		if (b == BASE_HEX) r = BASE_HEX;
		return r;
	endfunction

	function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] base);
		logic [4:0] d;
		d = DIGIT_NONE;
		if (base == BASE_BIN) begin
			if (c == CH_ZERO || c == CH_ONE) d = 5'(c & LOW_NIB);
		end else if (c inside {[CH_ZERO:CH_NINE]}) begin
			d = 5'(c & LOW_NIB);
		end else if (base == BASE_HEX) begin
			// letters a-f / A-F: low nibble is 1..6, add nine
			if (c inside {[CH_LA:CH_LF]} || c inside {[CH_UA:CH_UF]})
				d = 5'(c & LOW_NIB) + 5'd9;
		end
		return d;
	endfunction

endpackage

// ----- src/itp_char_step.sv -----
module itp_char_step import itp_pkg::*; #(
	parameter int MAX_COUNT = 255,
	parameter int CW = 8
) (
	input  cfg_t           cfg,
	input  parse_st_t      cur,
	input  logic [CW-1:0]  cnt,
	input  logic [7:0]     c,
	input  logic           last,
	output parse_st_t      nxt,
	output logic [CW-1:0]  cnt_nxt,
	output fin_t           fin,
	output logic [CW-1:0]  fin_cnt
);

	parse_st_t     st;
	logic [1:0]    add;
	logic          stop;
	logic [4:0]    d;
	logic [63:0]   w;
	logic [64:0]   sum;
	logic [CW:0]   cnt_sum;
	logic [CW-1:0] cnt_sat;

	always_comb begin
		st   = cur;
		add  = 2'd0;
		stop = 1'b0;
		w    = '0;
		sum  = '0;

		if (st.phase == PH_SPACES) begin
			st.base = decode_base(cfg.default_base);
			if (cfg.skip_spaces && c == CH_SPACE) begin
				add  = 2'd1;
				stop = 1'b1;
			end else begin
				st.phase = PH_AFTERSIGN;
				if (cfg.signed_mode && cfg.allow_sign && (c == CH_MINUS || c == CH_PLUS)) begin
					st.neg = (c == CH_MINUS);
					add    = 2'd1;
					stop   = 1'b1;
				end
			end
		end

		if (!stop && st.phase == PH_AFTERSIGN) begin
			// hold a leading zero until the next beat shows whether it opens a prefix
			if (cfg.allow_prefix && c == CH_ZERO) begin
				st.phase = PH_ZERO;
				stop     = 1'b1;
			end else begin
				st.phase = PH_FIRST;
			end
		end

		if (!stop && st.phase == PH_ZERO) begin
			if ((c | CASE_BIT) == CH_LB && st.base != BASE_HEX) begin
				st.base  = BASE_BIN;
				add      = 2'd2;
				st.phase = PH_FIRST;
				stop     = 1'b1;
			end else if ((c | CASE_BIT) == CH_LX && st.base != BASE_BIN) begin
				st.base  = BASE_HEX;
				add      = 2'd2;
				st.phase = PH_FIRST;
				stop     = 1'b1;
			end else begin
				// the held zero was a digit; this beat continues as a digit
				st.acc   = '0;
				add      = 2'd1;
				st.phase = PH_DIGITS;
			end
		end

		d = digit_of(c, st.base);

		if (!stop && st.phase == PH_FIRST) begin
			if (d == DIGIT_NONE) begin
				st.err   = ERR_INVAL;
				st.phase = PH_DONE;
			end else begin
				st.acc   = 64'(d);
				add      = add + 2'd1;
				st.phase = PH_DIGITS;
			end
			stop = 1'b1;
		end

		if (!stop && st.phase == PH_DIGITS) begin
			if (d == DIGIT_NONE) begin
				st.phase = PH_DONE;
			end else begin
				case (st.base)
					BASE_BIN: begin
						if (st.acc[63]) begin
							st.err   = ERR_RANGE;
							st.phase = PH_DONE;
						end else begin
							st.acc = {st.acc[62:0], d[0]};
							add    = add + 2'd1;
						end
					end
					BASE_HEX: begin
						if (st.acc[63:60] != 4'd0) begin
							st.err   = ERR_RANGE;
							st.phase = PH_DONE;
						end else begin
							st.acc = {st.acc[59:0], d[3:0]};
							add    = add + 2'd1;
						end
					end
					default: begin
						if (st.acc > DEC_LIMIT) begin
							st.err   = ERR_RANGE;
							st.phase = PH_DONE;
						end else begin
							// times ten as x8 + x2; cannot wrap below the limit
							w   = {st.acc[60:0], 3'b000} + {st.acc[62:0], 1'b0};
							sum = {1'b0, w} + 65'(d);
							if (sum[64]) begin
								st.err   = ERR_RANGE;
								st.phase = PH_DONE;
							end else begin
								st.acc = sum[63:0];
								add    = add + 2'd1;
							end
						end
					end
				endcase
			end
		end

		// string ends on a held zero: it is the digit zero
		if (last && st.phase == PH_ZERO) begin
			st.acc   = '0;
			add      = add + 2'd1;
			st.phase = PH_DIGITS;
		end

		cnt_sum = {1'b0, cnt} + (CW+1)'(add);
		cnt_sat = (cnt_sum > (CW+1)'(MAX_COUNT)) ? CW'(MAX_COUNT) : cnt_sum[CW-1:0];

		fin.acc = st.acc;
		fin.neg = st.neg;
		fin.err = st.err;
		if (st.err == ERR_NONE && st.phase != PH_DIGITS && st.phase != PH_DONE)
			fin.err = ERR_INVAL;
		fin_cnt = cnt_sat;

		if (last) begin
			nxt.phase = PH_SPACES;
			nxt.acc   = '0;
			nxt.neg   = 1'b0;
			nxt.base  = decode_base(cfg.default_base);
			nxt.err   = ERR_NONE;
			cnt_nxt   = '0;
		end else begin
			nxt     = st;
			cnt_nxt = cnt_sat;
		end
	end

endmodule

// ----- src/itp_range_check.sv -----
module itp_range_check import itp_pkg::*; #(
	parameter int CW = 8
) (
	input  cfg_t          cfg,
	input  fin_t          fin,
	input  logic [CW-1:0] cnt,
	output logic [63:0]   value,
	output logic [1:0]    error_code,
	output logic [7:0]    consumed_count
);

	localparam int XW = (CW > 8) ? CW : 8;

	logic [1:0]    err;
	logic [63:0]   v;
	logic [XW-1:0] cnt_x;

	always_comb begin
		err = fin.err;
		v   = '0;
		if (err == ERR_NONE) begin
			if (cfg.signed_mode) begin
				if (fin.neg) begin
					if (fin.acc > SIGN_BIT) err = ERR_RANGE;
					else v = 64'd0 - fin.acc;
				end else begin
					if (fin.acc[63]) err = ERR_RANGE;
					else v = fin.acc;
				end
				if (err == ERR_NONE && ($signed(v) < $signed(cfg.lower_bound)
						|| $signed(v) > $signed(cfg.upper_bound)))
					err = ERR_RANGE;
			end else begin
				v = fin.acc;
				if (v > cfg.upper_bound) err = ERR_RANGE;
			end
		end

		cnt_x = XW'(cnt);
		if (err != ERR_NONE) begin
			value          = '0;
			consumed_count = '0;
		end else begin
			value          = v;
			consumed_count = (cnt_x > XW'(8'hFF)) ? 8'hFF : cnt_x[7:0];
		end
		error_code = err;
	end

endmodule

// ----- src/integer_text_parser.sv -----
// Streaming integer parser: feed one character per beat on the input channel, with
// last_char set on the final one, and one result beat comes out per string carrying
// the value (two's complement in signed mode), an error code and the number of
// characters consumed. The block takes one character every cycle with no gaps between
// strings while the output is not stalled. A result goes from the input register
// through the character update into the finish register, then through the limit
// check into the output register. The one-character rate is set by the accumulator
// update, a times-ten shift-add with carry check. A held result does not block input
// until a second finished result is waiting behind it.
// Configuration writes must be made only while no string is in flight.
module integer_text_parser import itp_pkg::*; #(
	parameter int MAX_COUNT = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] value,
	output logic [1:0]  error_code,
	output logic [7:0]  consumed_count
);

	localparam int CW = $clog2(MAX_COUNT + 1);

	cfg_t          cfg_q;
	parse_st_t     st_q;
	logic [CW-1:0] cnt_q;

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          last_s1;

	logic          valid_s2;
	fin_t          fin_s2;
	logic [CW-1:0] cnt_s2;

	logic          out_valid_q;
	logic [63:0]   value_q;
	logic [1:0]    error_code_q;
	logic [7:0]    consumed_count_q;

	parse_st_t     st_nxt;
	logic [CW-1:0] cnt_nxt;
	fin_t          fin_nxt;
	logic [CW-1:0] fin_cnt;
	logic [63:0]   chk_value;
	logic [1:0]    chk_err;
	logic [7:0]    chk_cnt;

	logic out_ready, s2_ready, s1_adv, s2_adv, in_acc;

	assign out_ready = !out_valid_q || !out_stall;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s2_adv    = valid_s2 && out_ready;
	assign s1_adv    = valid_s1 && (!last_s1 || s2_ready);
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_acc    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.signed_mode  <= 1'b1;
			cfg_q.lower_bound  <= SIGN_BIT;
			cfg_q.upper_bound  <= ~SIGN_BIT;
			cfg_q.skip_spaces  <= 1'b1;
			cfg_q.allow_sign   <= 1'b1;
			cfg_q.default_base <= BASE_DEC;
			cfg_q.allow_prefix <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIGNED_MODE:  cfg_q.signed_mode  <= cfg_data[0];
				REG_LOWER_BOUND:  cfg_q.lower_bound  <= cfg_data;
				REG_UPPER_BOUND:  cfg_q.upper_bound  <= cfg_data;
				REG_SKIP_SPACES:  cfg_q.skip_spaces  <= cfg_data[0];
				REG_ALLOW_SIGN:   cfg_q.allow_sign   <= cfg_data[0];
				REG_DEFAULT_BASE: cfg_q.default_base <= cfg_data[1:0];
				REG_ALLOW_PREFIX: cfg_q.allow_prefix <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1 <= char_byte;
			last_s1 <= last_char;
		end
	end

	itp_char_step #(
		.MAX_COUNT(MAX_COUNT),
		.CW(CW)
	) u_step (
		.cfg(cfg_q),
		.cur(st_q),
		.cnt(cnt_q),
		.c(char_s1),
		.last(last_s1),
		.nxt(st_nxt),
		.cnt_nxt(cnt_nxt),
		.fin(fin_nxt),
		.fin_cnt(fin_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= PH_SPACES;
			st_q.acc   <= '0;
			st_q.neg   <= 1'b0;
			st_q.base  <= BASE_DEC;
			st_q.err   <= ERR_NONE;
			cnt_q      <= '0;
		end else if (s1_adv) begin
			st_q  <= st_nxt;
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_adv) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			fin_s2 <= fin_nxt;
			cnt_s2 <= fin_cnt;
		end
	end

	itp_range_check #(
		.CW(CW)
	) u_range (
		.cfg(cfg_q),
		.fin(fin_s2),
		.cnt(cnt_s2),
		.value(chk_value),
		.error_code(chk_err),
		.consumed_count(chk_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result beat while stalled
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			value_q          <= chk_value;
			error_code_q     <= chk_err;
			consumed_count_q <= chk_cnt;
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign error_code     = error_code_q;
	assign consumed_count = consumed_count_q;

endmodule

// ----- src/itp_checker.sv -----
module itp_checker import itp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] value,
	input logic [1:0]  error_code,
	input logic [7:0]  consumed_count
);

	// a failed parse reports nothing but its code
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> value == 64'd0 && consumed_count == 8'd0)
		else $error("error result carries value or count");

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code == ERR_NONE || error_code == ERR_INVAL
			|| error_code == ERR_RANGE)
		else $error("unused error code");

	// success needs at least one digit, so something was consumed
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_NONE |-> consumed_count != 8'd0)
		else $error("successful result with zero count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(error_code)
			&& $stable(consumed_count))
		else $error("stalled result beat changed");

endmodule

bind integer_text_parser itp_checker u_itp_checker (.*);
